// ----- hw/rtl/percent_encode_decode_assert.svh -----
// Assertion macros for the percent encoder / decoder.
// ped_assert_imp: same-cycle implication; ped_assert_nxt: next-cycle implication.
`ifndef PERCENT_ENCODE_DECODE_ASSERT_SVH
`define PERCENT_ENCODE_DECODE_ASSERT_SVH
`ifndef SYNTHESIS
`define PED_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("percent_encode_decode: assertion failed");
`define PED_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("percent_encode_decode: assertion failed");
`else
`define PED_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PED_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/ped_pkg.sv -----
package ped_pkg;

    // escape character
    localparam logic [7:0] C_PCT = 8'h25;

    // number of output words one input word can expand to
    localparam int unsigned C_MAX_OUT = 3;

    // decode escape tracking
    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,  // nothing held
        PEND_PCT   = 2'd1,  // a '%' is held
        PEND_DIGIT = 2'd2   // a '%' and its first digit are held
    } t_pend_state;

    typedef logic [7:0] t_byte;

    // letters, digits, - . _ ~
    function automatic logic is_unreserved(input t_byte c);
        is_unreserved = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                        (c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h2E ||
                        c == 8'h5F || c == 8'h7E;
    endfunction

    // nibble to upper-case hex character
    function automatic t_byte hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            hex_char = 8'h30 + {4'h0, v};
        end else begin
            hex_char = 8'h37 + {4'h0, v};
        end
    endfunction

    // hex character to value; anything else keeps its raw value
    function automatic t_byte digit_value(input t_byte c);
        if (c >= 8'h30 && c <= 8'h39) begin
            digit_value = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            digit_value = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            digit_value = c - 8'h37;
        end else begin
            digit_value = c;
        end
    endfunction

endpackage

// ----- hw/rtl/percent_encode_decode.sv -----
// Streaming percent (URL) encoder / decoder. One byte of a string enters per word, with
// i_last_byte on its final byte; i_cfg_decode_mode selects encoding (0) or decoding (1), and
// a write to it drops any half-received escape, so write it only between strings while the
// block is idle. Every input word is expanded into a three-entry buffer in the cycle it is
// accepted, and the buffer drains through the output register one word per cycle while
// i_out_ready is high. An input byte yields one output word if it passes through or
// completes an escape, three for an escaped byte in encode mode, two ('%' and the byte) for
// a byte that ends the string right after a '%' in decode mode, and none for a held '%' or
// first digit. The first output word passes through the buffer and then the output register
// before it is valid. The single output port limits the flow; the next input word is taken
// in the cycle the buffer hands over its last word.
`include "percent_encode_decode_assert.svh"

module percent_encode_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_decode_mode,
    // input words
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ped_pkg::t_byte      i_data_byte,
    input  logic                i_last_byte,
    // output words
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ped_pkg::t_byte      o_out_byte,
    output logic                o_run_end,
    output logic                o_string_end
);
    import ped_pkg::*;

    // state
    logic        r_mode;
    t_pend_state r_pend, n_pend;
    t_byte       r_held, n_held;

    // expansion buffer
    t_byte       r_buf [C_MAX_OUT];
    logic [1:0]  r_buf_cnt;
    logic        r_buf_last;

    // output register
    logic        r_out_valid;
    t_byte       r_out_byte;
    logic        r_out_run_end;
    logic        r_out_str_end;

    // expansion of the current input word
    t_byte       n_buf [C_MAX_OUT];
    logic [1:0]  n_cnt;
    t_byte       w_a, w_b;

    logic        w_in_acc;
    logic        w_cfg_acc;
    logic        w_out_load;
    logic        w_pop;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid & o_cfg_ready;

    // output register takes a word when empty or being emptied
    assign w_out_load = (r_buf_cnt != 2'd0) && (!r_out_valid || i_out_ready);
    assign w_pop      = w_out_load;

    assign o_in_ready = (r_buf_cnt == 2'd0) || (w_pop && r_buf_cnt == 2'd1);
    assign w_in_acc   = i_in_valid & o_in_ready;

    assign w_a = digit_value(r_held);
    assign w_b = digit_value(i_data_byte);

    // next escape state
    always_comb begin
        n_pend = r_pend;
        n_held = r_held;
        if (r_mode) begin
            case (r_pend)
                PEND_NONE: begin
                    if (i_data_byte == C_PCT && !i_last_byte) begin
                        n_pend = PEND_PCT;
                    end
                end
                PEND_PCT: begin
                    if (!i_last_byte) begin
                        n_pend = PEND_DIGIT;
                        n_held = i_data_byte;
                    end else begin
                        n_pend = PEND_NONE;
                        n_held = '0;
                    end
                end
                PEND_DIGIT: begin
                    n_pend = PEND_NONE;
                    n_held = '0;
                end
                default: begin
                    n_pend = PEND_NONE;
                    n_held = '0;
                end
            endcase
            if (i_last_byte) begin
                n_pend = PEND_NONE;
                n_held = '0;
            end
        end
    end

    // output words for the current input word
    always_comb begin
        n_cnt = 2'd0;
        for (int k = 0; k < C_MAX_OUT; k++) begin
            n_buf[k] = i_data_byte;
        end
        if (!r_mode) begin
            if (is_unreserved(i_data_byte)) begin
                n_cnt = 2'd1;
            end else begin
                n_cnt    = 2'd3;
                n_buf[0] = C_PCT;
                n_buf[1] = hex_char(i_data_byte[7:4]);
                n_buf[2] = hex_char(i_data_byte[3:0]);
            end
        end else begin
            case (r_pend)
                PEND_NONE: begin
                    if (!(i_data_byte == C_PCT && !i_last_byte)) begin
                        n_cnt = 2'd1;
                    end
                end
                PEND_PCT: begin
                    if (i_last_byte) begin
                        n_cnt    = 2'd2;
                        n_buf[0] = C_PCT;
                    end
                end
                PEND_DIGIT: begin
                    n_cnt    = 2'd1;
                    n_buf[0] = {w_a[3:0], 4'h0} | w_b;
                end
                default: begin
                    n_cnt = 2'd0;
                end
            endcase
        end
    end

    // mode and escape state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_pend <= PEND_NONE;
            r_held <= '0;
        end else if (w_cfg_acc) begin
            r_mode <= i_cfg_decode_mode;
            r_pend <= PEND_NONE;
            r_held <= '0;
        end else if (w_in_acc) begin
            r_pend <= n_pend;
            r_held <= n_held;
        end
    end

    // expansion buffer: load on accept, shift out one word per pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_cnt <= 2'd0;
        end else if (w_in_acc) begin
            r_buf_cnt <= n_cnt;
        end else if (w_pop) begin
            r_buf_cnt <= r_buf_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_buf      <= n_buf;
            r_buf_last <= i_last_byte;
        end else if (w_pop) begin
            r_buf[0] <= r_buf[1];
            r_buf[1] <= r_buf[2];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_byte    <= r_buf[0];
            r_out_run_end <= (r_buf_cnt == 2'd1);
            r_out_str_end <= (r_buf_cnt == 2'd1) && r_buf_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_run_end    = r_out_run_end;
    assign o_string_end = r_out_str_end;

    // checks
    `PED_ASSERT_IMP(a_enc_no_pend, i_clk, i_rst_n, !r_mode, r_pend == PEND_NONE)
    `PED_ASSERT_IMP(a_str_end_run_end, i_clk, i_rst_n, o_out_valid && o_string_end, o_run_end)
    `PED_ASSERT_NXT(a_digit_after_pct, i_clk, i_rst_n, r_pend == PEND_NONE, r_pend != PEND_DIGIT)

endmodule
